/* hw/rtl/nlcd_pkg.sv */
// nlcd_pkg: shared types and constants of the neighbor label cell detector
// payload structs, configuration register codes and reset values
// no dependencies
package nlcd_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned POS_W      = 10;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST    = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST   = 11'd1024;
  localparam logic [DIGIT_W-1:0]    TARGET_VALUE_RST   = 4'd1;
  localparam logic [DIGIT_W-1:0]    NEIGHBOR_VALUE_RST = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 4'd0,
    REG_FRAME_HEIGHT   = 4'd1,
    REG_TARGET_VALUE   = 4'd2,
    REG_NEIGHBOR_VALUE = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] cell_value;
    logic               is_flush;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] match_row;
    logic [POS_W-1:0] match_col;
  } out_item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] target_value;
    logic [DIGIT_W-1:0] neighbor_value;
  } digits_t;

endpackage

/* hw/rtl/nlcd_ram.sv */
// nlcd_ram: generic simple dual-port ram, one write and one registered read port
// read returns the old contents on a same-address write
// no dependencies
module nlcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/nlcd_scan.sv */
// nlcd_scan: configuration registers, dimension clamping and raster position counters
// gives the column, row and effective value of the cell being transferred
// depends on nlcd_pkg
module nlcd_scan import nlcd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]            cfg_data,
  input  logic                             accept,
  input  in_item_t                         item,
  output logic [$clog2(MAX_WIDTH)-1:0]     pos_c,
  output logic [$clog2(MAX_HEIGHT+3)-1:0]  pos_r,
  output logic [DIGIT_W-1:0]               pos_v,
  output logic [$clog2(MAX_WIDTH+1)-1:0]   w_dim,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]  h_dim,
  output digits_t                          digits
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 3);
  localparam int unsigned WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HD_W  = $clog2(MAX_HEIGHT + 1);

  logic [CFG_DATA_W-1:0] frame_width_r, frame_height_r;
  digits_t               digits_r;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic                  wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r           <= FRAME_WIDTH_RST;
      frame_height_r          <= FRAME_HEIGHT_RST;
      digits_r.target_value   <= TARGET_VALUE_RST;
      digits_r.neighbor_value <= NEIGHBOR_VALUE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:    frame_width_r           <= cfg_data;
        REG_FRAME_HEIGHT:   frame_height_r          <= cfg_data;
        REG_TARGET_VALUE:   digits_r.target_value   <= cfg_data[DIGIT_W-1:0];
        REG_NEIGHBOR_VALUE: digits_r.neighbor_value <= cfg_data[DIGIT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to 1..MAX
  always_comb begin
    if (frame_width_r == '0) begin
      w_dim = WD_W'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_dim = WD_W'(MAX_WIDTH);
    end else begin
      w_dim = WD_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_dim = HD_W'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_dim = HD_W'(MAX_HEIGHT);
    end else begin
      h_dim = HD_W'(frame_height_r);
    end
  end

  assign digits = digits_r;

  // a column left beyond a narrowed width moves to the next row
  always_comb begin
    wrap  = (col_r >= w_dim);
    pos_c = wrap ? '0 : col_r;
    pos_r = wrap ? row_r + ROW_W'(1) : row_r;
    pos_v = (item.is_flush || pos_r >= h_dim) ? '0 : item.cell_value;

    if (pos_r >= ROW_W'(h_dim) + ROW_W'(1)) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (WD_W'(pos_c) + WD_W'(1) >= w_dim) begin
      col_nxt = '0;
      row_nxt = pos_r + ROW_W'(1);
    end else begin
      col_nxt = pos_c + COL_W'(1);
      row_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* hw/rtl/nlcd_window.sv */
// nlcd_window: 3x3 window registers and the neighbor test for the center cell
// the newest column comes in from the line memory and the current cell
// depends on nlcd_pkg
module nlcd_window import nlcd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  logic [DIGIT_W-1:0]               top,
  input  logic [DIGIT_W-1:0]               mid,
  input  logic [DIGIT_W-1:0]               bot,
  input  logic [$clog2(MAX_WIDTH)-1:0]     pos_c,
  input  logic [$clog2(MAX_HEIGHT+3)-1:0]  pos_r,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   w_dim,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]  h_dim,
  input  digits_t                          digits,
  output logic                             found,
  output out_item_t                        result
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 3);
  localparam int unsigned WD_W  = $clog2(MAX_WIDTH + 1);

  // left and center columns of the window, index 0 is the top row
  logic [DIGIT_W-1:0] lcol_r [3];
  logic [DIGIT_W-1:0] ccol_r [3];

  logic [ROW_W-1:0]   qr;
  logic [COL_W-1:0]   qc;
  logic               q_ok, up_ok, dn_ok, lf_ok, rt_ok, hit;
  logic [DIGIT_W-1:0] nb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        lcol_r[i] <= '0;
        ccol_r[i] <= '0;
      end
    end else if (load) begin
      for (int i = 0; i < 3; i++) begin
        lcol_r[i] <= ccol_r[i];
      end
      ccol_r[0] <= top;
      ccol_r[1] <= mid;
      ccol_r[2] <= bot;
    end
  end

  // decided cell sits one row and one column behind the current position (at column zero: two rows back, last column)
  always_comb begin
    nb = digits.neighbor_value;
    if (pos_c != '0) begin
      q_ok = (pos_r >= ROW_W'(1));
      qr   = pos_r - ROW_W'(1);
      qc   = pos_c - COL_W'(1);
    end else begin
      q_ok = (pos_r >= ROW_W'(2));
      qr   = pos_r - ROW_W'(2);
      qc   = COL_W'(w_dim - WD_W'(1));
    end
    up_ok = (qr != '0);
    dn_ok = (qr + ROW_W'(1) < h_dim);
    lf_ok = (qc != '0);
    rt_ok = (WD_W'(qc) + WD_W'(1) < w_dim);

    hit = (up_ok && lf_ok && lcol_r[0] == nb) ||
          (up_ok && ccol_r[0] == nb) ||
          (up_ok && rt_ok && top == nb) ||
          (lf_ok && lcol_r[1] == nb) ||
          (rt_ok && mid == nb) ||
          (dn_ok && lf_ok && lcol_r[2] == nb) ||
          (dn_ok && ccol_r[2] == nb) ||
          (dn_ok && rt_ok && bot == nb);

    found = q_ok && (qr < h_dim) && (ccol_r[1] == digits.target_value) && hit;
    result.match_row = POS_W'(qr);
    result.match_col = POS_W'(qc);
  end

endmodule

/* hw/rtl/neighbor_label_cell_detector_core.sv */
// neighbor_label_cell_detector_core: top level of the 3x3 neighbor cell detector
// depends on nlcd_pkg, nlcd_scan, nlcd_ram, nlcd_window
//
// Takes one grid cell per clock in raster order and reports the row and column of every
// cell equal to target_value that has an in-frame neighbor equal to neighbor_value. A
// report for a cell is decided frame_width+1 items after it, so after each frame the host
// sends frame_width+1 flush items; the deciding item is registered in stage 1 and the
// result then in the output register. Throughput is one item per cycle, held up only by
// out_stall; the pace is set by the line memory, which holds the two previous rows as one
// entry per column and is read once and written once per item. The line memory needs no
// initialization pass. Configuration registers are written through the cfg port, which is
// always ready; write them only while no item is in flight.
module neighbor_label_cell_detector_core import nlcd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 3);
  localparam int unsigned WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HD_W  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LW    = 2 * DIGIT_W;

  logic               accept;
  logic [COL_W-1:0]   pos_c;
  logic [ROW_W-1:0]   pos_r;
  logic [DIGIT_W-1:0] pos_v;
  logic [WD_W-1:0]    w_dim;
  logic [HD_W-1:0]    h_dim;
  digits_t            digits;

  // stage 1: transferred cell waiting on its line memory read
  logic               s1_valid_r, s1_valid_nxt;
  logic [COL_W-1:0]   s1_c_r;
  logic [ROW_W-1:0]   s1_r_r;
  logic [DIGIT_W-1:0] s1_v_r;
  logic               fwd_r;
  logic [LW-1:0]      fwd_data_r;
  logic               s1_go;

  logic [LW-1:0]      ram_rdata, line_col, line_wdata;
  logic               found;
  out_item_t          result;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;

  assign cfg_ready = 1'b1;
  assign s1_go     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_go;
  assign accept    = in_valid && !in_stall;

  nlcd_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (in_data),
    .pos_c     (pos_c),
    .pos_r     (pos_r),
    .pos_v     (pos_v),
    .w_dim     (w_dim),
    .h_dim     (h_dim),
    .digits    (digits)
  );

  // entry per column: upper digit is two rows back, lower digit one row back
  assign line_wdata = {line_col[DIGIT_W-1:0], s1_v_r};

  nlcd_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_c_r),
    .wdata (line_wdata),
    .re    (accept),
    .raddr (pos_c),
    .rdata (ram_rdata)
  );

  // same column written and read at one edge (width of one): bypass the memory
  assign line_col = fwd_r ? fwd_data_r : ram_rdata;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        fwd_r <= s1_go && (s1_c_r == pos_c);
      end else if (s1_go) begin
        fwd_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c_r     <= pos_c;
      s1_r_r     <= pos_r;
      s1_v_r     <= pos_v;
      fwd_data_r <= line_wdata;
    end
  end

  nlcd_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (s1_go),
    .top    (line_col[LW-1:DIGIT_W]),
    .mid    (line_col[DIGIT_W-1:0]),
    .bot    (s1_v_r),
    .pos_c  (s1_c_r),
    .pos_r  (s1_r_r),
    .w_dim  (w_dim),
    .h_dim  (h_dim),
    .digits (digits),
    .found  (found),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && found) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && found) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input is only held off by a stage 1 cell that cannot move on
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked stage 1 cell");

  // a blocked stage 1 cell is kept, not dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_c_r) && $stable(s1_r_r)))
    else $error("stage 1 cell lost while blocked");

  // bypass only stands for a loaded stage 1 cell
  a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("line memory bypass without a stage 1 cell");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result overwritten");

endmodule
